// ===== rtl/core/msgs_pkg.sv =====
// Shared constants, types and neighbour tables for the mass-spring grid step core.
`default_nettype none

package msgs_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int NVERT      = GRID_SIDE * GRID_SIDE;
  localparam int VERT_W     = $clog2(NVERT);
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;
  localparam int MEM_DEPTH  = NUM_AXES * NVERT;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int NB_SLOTS   = 8;
  localparam int ACC_W      = 36;

  // 0.3 in Q16.16
  localparam logic signed [32:0] SPREAD_Q16 = 33'sd19661;

  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_PULL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] REG_SPRING  = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_DT      = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PULL,
    ST_READ,
    ST_COPY,
    ST_COPY_END,
    ST_VLOAD,
    ST_VCAP,
    ST_NB_ADDR,
    ST_NB_MUL,
    ST_NB_ACC,
    ST_I0,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_I4,
    ST_I5,
    ST_I6
  } state_t;

  // Row offset of each neighbour slot.
  function automatic int nb_dr(input logic [2:0] s);
    case (s)
      3'd0, 3'd1, 3'd2: return -1;
      3'd3, 3'd4:       return 0;
      default:          return 1;
    endcase
  endfunction

  // Column offset of each neighbour slot.
  function automatic int nb_dc(input logic [2:0] s);
    case (s)
      3'd0, 3'd3, 3'd5: return -1;
      3'd1, 3'd6:       return 0;
      default:          return 1;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msgs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module msgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mass_spring_grid_step_core.sv =====
// Top level of the mass-spring grid step core: sequencer, shared multiplier and state RAMs.
`default_nettype none

// The core keeps position, velocity and force of every vertex of a 16 by 16 cloth grid in
// RAMs, one word per vertex and axis, and runs every command through one shared 33 by 33
// multiplier under a small sequencer. A command is taken when start is high and busy is low;
// busy stays high until the command is finished. A pull writes the force of each axis in
// turn. A read fetches the position of each axis in turn, after which result_valid is high
// for exactly one cycle with read_index and pos_x/pos_y/pos_z; the receiver cannot stall it,
// so it must take the result in that cycle.
// A step runs axis by axis. Each axis first copies the force RAM into the old-force RAM (one
// entry a cycle), then visits every vertex: ST_VLOAD and ST_VCAP fetch position and
// velocity, ST_NB_ADDR, ST_NB_MUL and ST_NB_ACC serve each neighbour that lies on the grid,
// ST_NB_ADDR alone skips each neighbour slot that falls off the edge (the old-force RAM port
// and the multiplier are shared by all of them), and ST_I0 to ST_I6 do the spring, damping
// and trapezoidal update. Pull and read commands with a vertex index off the grid, and the
// unused opcode, finish at once with no result. After reset the core writes the rest
// positions and zero velocities and forces into the RAMs; busy is high during that pass,
// while the configuration port already accepts writes. Configuration should only be written
// while the core is idle.

module mass_spring_grid_step_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           opcode,
  input  wire logic [7:0]                           vertex_index,
  input  wire logic signed [31:0]                   target_x,
  input  wire logic signed [31:0]                   target_y,
  input  wire logic signed [31:0]                   target_z,
  output logic                                      result_valid,
  output logic [7:0]                                read_index,
  output logic signed [31:0]                        pos_x,
  output logic signed [31:0]                        pos_y,
  output logic signed [31:0]                        pos_z,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [msgs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
  localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Shift a product right by 16 (or 17) with rounding half up, then saturate.
  function automatic logic signed [31:0] round_sh(input logic signed [65:0] p,
                                                  input logic by17);
    logic signed [66:0] q;
    if (by17) begin
      q = (67'(p) + 67'sd65536) >>> 17;
    end else begin
      q = (67'(p) + 67'sd32768) >>> 16;
    end
    return sat32(q);
  endfunction

  // RAM address of one axis of one vertex; an axis past the last one maps to axis 0.
  function automatic logic [msgs_pkg::ADDR_W-1:0] mem_addr(
      input logic [msgs_pkg::AXIS_W-1:0] axis, input logic [msgs_pkg::VERT_W-1:0] v);
    int a;
    a = (int'(axis) < msgs_pkg::NUM_AXES) ? int'(axis) : 0;
    return msgs_pkg::ADDR_W'(a * msgs_pkg::NVERT + int'(v));
  endfunction

  // Rest point of a vertex on one axis: (column, 0, row) in Q16.16.
  function automatic logic signed [31:0] rest_of(input logic [msgs_pkg::AXIS_W-1:0] axis,
                                                 input logic [msgs_pkg::SIDE_W-1:0] r,
                                                 input logic [msgs_pkg::SIDE_W-1:0] c);
    if (axis == msgs_pkg::AXIS_X) begin
      return {16'(c), 16'd0};
    end else if (axis == msgs_pkg::AXIS_Z) begin
      return {16'(r), 16'd0};
    end
    return 32'sd0;
  endfunction

  msgs_pkg::state_t state, state_next;

  logic [msgs_pkg::AXIS_W-1:0] comp;
  logic [msgs_pkg::VERT_W-1:0] vtx;
  logic [msgs_pkg::SIDE_W-1:0] row;
  logic [msgs_pkg::SIDE_W-1:0] col;
  logic [2:0]                  slot;

  logic signed [31:0] spring_gain;
  logic signed [31:0] damping_gain;
  logic [30:0]        time_step;

  logic [7:0]                  idx_reg;
  logic signed [31:0]          tgt_x, tgt_y, tgt_z;
  logic signed [31:0]          pos0, vel0, fh, f, v1;
  logic signed [msgs_pkg::ACC_W-1:0] acc;
  logic signed [65:0]          prod;
  logic signed [32:0]          mul_a, mul_b;

  logic                        pos_we, vel_we, frc_we, ofrc_we;
  logic [msgs_pkg::ADDR_W-1:0] pos_waddr, vel_waddr, frc_waddr, ofrc_waddr;
  logic [msgs_pkg::ADDR_W-1:0] pos_raddr, vel_raddr, frc_raddr, ofrc_raddr;
  logic [31:0]                 pos_wdata, vel_wdata, frc_wdata, ofrc_wdata;
  logic [31:0]                 pos_rdata, vel_rdata, frc_rdata, ofrc_rdata;

  logic                        last_vtx, idx_ok, start_ok, cfg_wr, nb_ok;
  logic [msgs_pkg::VERT_W-1:0] nb_vtx;
  logic signed [31:0]          rest_cur, tgt_sel, pull_val, nb_term, fe, f_new, v1_new, pos_new;
  logic signed [32:0]          pull_diff;
  logic signed [37:0]          pull_mul;
  int                          nb_row, nb_col;

  assign last_vtx = (vtx == msgs_pkg::VERT_W'(msgs_pkg::NVERT - 1));
  assign idx_ok   = (int'(vertex_index) < msgs_pkg::NVERT);
  assign start_ok = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Neighbour position and whether it lies on the grid.
  always_comb begin
    nb_row = int'(row) + msgs_pkg::nb_dr(slot);
    nb_col = int'(col) + msgs_pkg::nb_dc(slot);
    nb_ok  = (nb_row >= 0) && (nb_row < msgs_pkg::GRID_SIDE) &&
             (nb_col >= 0) && (nb_col < msgs_pkg::GRID_SIDE);
    nb_vtx = msgs_pkg::VERT_W'(int'(vtx) + msgs_pkg::nb_dr(slot) * msgs_pkg::GRID_SIDE +
                               msgs_pkg::nb_dc(slot));
  end

  // Datapath values that feed register writes.
  always_comb begin
    rest_cur  = rest_of(comp, row, col);
    case (comp)
      2'd0:    tgt_sel = tgt_x;
      2'd1:    tgt_sel = tgt_y;
      default: tgt_sel = tgt_z;
    endcase
    pull_diff = 33'(rest_cur) - 33'(tgt_sel);
    pull_mul  = (38'(pull_diff) <<< 3) + (38'(pull_diff) <<< 1);
    pull_val  = sat32(67'(pull_mul));
    nb_term   = round_sh(prod, 1'b0);
    fe        = sat32(67'(acc));
    f_new     = sat32(67'(fe) + 67'(fh) + 67'(round_sh(prod, 1'b0)));
    v1_new    = sat32(67'(vel0) + 67'(round_sh(prod, 1'b0)));
    pos_new   = sat32(67'(pos0) + 67'(round_sh(prod, 1'b1)));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      msgs_pkg::ST_CLEAR: begin
        if (last_vtx && comp == msgs_pkg::AXIS_Z) begin
          state_next = msgs_pkg::ST_IDLE;
        end
      end
      msgs_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            msgs_pkg::OP_STEP: state_next = msgs_pkg::ST_COPY;
            msgs_pkg::OP_PULL: state_next = idx_ok ? msgs_pkg::ST_PULL : msgs_pkg::ST_IDLE;
            msgs_pkg::OP_READ: state_next = idx_ok ? msgs_pkg::ST_READ : msgs_pkg::ST_IDLE;
            default:           state_next = msgs_pkg::ST_IDLE;
          endcase
        end
      end
      msgs_pkg::ST_PULL: begin
        if (comp == msgs_pkg::AXIS_Z) begin
          state_next = msgs_pkg::ST_IDLE;
        end
      end
      msgs_pkg::ST_READ: begin
        if (comp == msgs_pkg::AXIS_W'(msgs_pkg::NUM_AXES)) begin
          state_next = msgs_pkg::ST_IDLE;
        end
      end
      msgs_pkg::ST_COPY: begin
        if (last_vtx) begin
          state_next = msgs_pkg::ST_COPY_END;
        end
      end
      msgs_pkg::ST_COPY_END: state_next = msgs_pkg::ST_VLOAD;
      msgs_pkg::ST_VLOAD:    state_next = msgs_pkg::ST_VCAP;
      msgs_pkg::ST_VCAP:     state_next = msgs_pkg::ST_NB_ADDR;
      msgs_pkg::ST_NB_ADDR: begin
        if (nb_ok) begin
          state_next = msgs_pkg::ST_NB_MUL;
        end else if (slot == 3'(msgs_pkg::NB_SLOTS - 1)) begin
          state_next = msgs_pkg::ST_I0;
        end
      end
      msgs_pkg::ST_NB_MUL: state_next = msgs_pkg::ST_NB_ACC;
      msgs_pkg::ST_NB_ACC: begin
        state_next = (slot == 3'(msgs_pkg::NB_SLOTS - 1)) ? msgs_pkg::ST_I0
                                                           : msgs_pkg::ST_NB_ADDR;
      end
      msgs_pkg::ST_I0: state_next = msgs_pkg::ST_I1;
      msgs_pkg::ST_I1: state_next = msgs_pkg::ST_I2;
      msgs_pkg::ST_I2: state_next = msgs_pkg::ST_I3;
      msgs_pkg::ST_I3: state_next = msgs_pkg::ST_I4;
      msgs_pkg::ST_I4: state_next = msgs_pkg::ST_I5;
      msgs_pkg::ST_I5: state_next = msgs_pkg::ST_I6;
      msgs_pkg::ST_I6: begin
        if (!last_vtx) begin
          state_next = msgs_pkg::ST_VLOAD;
        end else if (comp == msgs_pkg::AXIS_Z) begin
          state_next = msgs_pkg::ST_IDLE;
        end else begin
          state_next = msgs_pkg::ST_COPY;
        end
      end
      default: state_next = msgs_pkg::ST_IDLE;
    endcase
  end

  // RAM controls and multiplier operands.
  always_comb begin
    busy       = (state != msgs_pkg::ST_IDLE);
    pos_we     = 1'b0;
    vel_we     = 1'b0;
    frc_we     = 1'b0;
    ofrc_we    = 1'b0;
    pos_waddr  = mem_addr(comp, vtx);
    vel_waddr  = mem_addr(comp, vtx);
    frc_waddr  = mem_addr(comp, vtx);
    ofrc_waddr = mem_addr(comp, vtx);
    pos_raddr  = mem_addr(comp, vtx);
    vel_raddr  = mem_addr(comp, vtx);
    frc_raddr  = mem_addr(comp, vtx);
    ofrc_raddr = mem_addr(comp, nb_vtx);
    pos_wdata  = pos_new;
    vel_wdata  = v1;
    frc_wdata  = f;
    ofrc_wdata = frc_rdata;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      msgs_pkg::ST_CLEAR: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        frc_we    = 1'b1;
        pos_wdata = rest_cur;
        vel_wdata = '0;
        frc_wdata = '0;
      end
      msgs_pkg::ST_PULL: begin
        frc_we    = 1'b1;
        frc_wdata = pull_val;
      end
      msgs_pkg::ST_COPY: begin
        ofrc_we    = (vtx != '0);
        ofrc_waddr = mem_addr(comp, vtx - 1'b1);
      end
      msgs_pkg::ST_COPY_END: ofrc_we = 1'b1;
      msgs_pkg::ST_NB_MUL: begin
        mul_a = 33'(signed'(ofrc_rdata));
        mul_b = msgs_pkg::SPREAD_Q16;
      end
      msgs_pkg::ST_I0: begin
        mul_a = 33'(rest_cur) - 33'(pos0);
        mul_b = 33'(spring_gain);
      end
      msgs_pkg::ST_I1: begin
        mul_a = 33'(vel0);
        mul_b = 33'(damping_gain);
      end
      msgs_pkg::ST_I3: begin
        mul_a = 33'(f);
        mul_b = {2'b00, time_step};
      end
      msgs_pkg::ST_I5: begin
        mul_a = 33'(vel0) + 33'(v1);
        mul_b = {2'b00, time_step};
      end
      msgs_pkg::ST_I6: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        frc_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Configuration read-back.
  always_comb begin
    case (paddr[3:2])
      msgs_pkg::REG_SPRING:  prdata = spring_gain;
      msgs_pkg::REG_DAMPING: prdata = damping_gain;
      msgs_pkg::REG_DT:      prdata = {1'b0, time_step};
      default:               prdata = '0;
    endcase
  end

  // Control registers: sequencer, counters, strobe and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= msgs_pkg::ST_CLEAR;
      comp         <= '0;
      vtx          <= '0;
      row          <= '0;
      col          <= '0;
      slot         <= '0;
      result_valid <= 1'b0;
      spring_gain  <= 32'sd65536;
      damping_gain <= 32'sd0;
      time_step    <= 31'd655;
    end else begin
      state        <= state_next;
      // The strobe follows the last cycle of a read, when the z word has arrived.
      result_valid <= (state == msgs_pkg::ST_READ) &&
                      (comp == msgs_pkg::AXIS_W'(msgs_pkg::NUM_AXES));
      if (cfg_wr) begin
        case (paddr[3:2])
          msgs_pkg::REG_SPRING:  spring_gain  <= pwdata;
          msgs_pkg::REG_DAMPING: damping_gain <= pwdata;
          msgs_pkg::REG_DT:      time_step    <= pwdata[30:0];
          default: ;
        endcase
      end
      case (state)
        msgs_pkg::ST_CLEAR, msgs_pkg::ST_COPY, msgs_pkg::ST_I6: begin
          if (last_vtx) begin
            // The copy pass holds the last index for its trailing write.
            if (state != msgs_pkg::ST_COPY) begin
              vtx  <= '0;
              row  <= '0;
              col  <= '0;
              comp <= comp + 1'b1;
            end
          end else begin
            vtx <= vtx + 1'b1;
            if (col == msgs_pkg::SIDE_W'(msgs_pkg::GRID_SIDE - 1)) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        msgs_pkg::ST_COPY_END: begin
          vtx <= '0;
          row <= '0;
          col <= '0;
        end
        msgs_pkg::ST_IDLE: begin
          if (start_ok) begin
            comp <= '0;
            if (opcode == msgs_pkg::OP_STEP) begin
              vtx <= '0;
              row <= '0;
              col <= '0;
            end else begin
              vtx <= msgs_pkg::VERT_W'(vertex_index);
              row <= msgs_pkg::SIDE_W'(int'(vertex_index) / msgs_pkg::GRID_SIDE);
              col <= msgs_pkg::SIDE_W'(int'(vertex_index) % msgs_pkg::GRID_SIDE);
            end
          end
        end
        msgs_pkg::ST_PULL: comp <= comp + 1'b1;
        msgs_pkg::ST_READ: comp <= comp + 1'b1;
        msgs_pkg::ST_VLOAD: slot <= '0;
        msgs_pkg::ST_NB_ADDR: begin
          if (!nb_ok && slot != 3'(msgs_pkg::NB_SLOTS - 1)) begin
            slot <= slot + 1'b1;
          end
        end
        msgs_pkg::ST_NB_ACC: slot <= slot + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (start_ok) begin
      idx_reg <= vertex_index;
      tgt_x   <= target_x;
      tgt_y   <= target_y;
      tgt_z   <= target_z;
    end
    case (state)
      msgs_pkg::ST_READ: begin
        case (comp)
          2'd1: pos_x <= pos_rdata;
          2'd2: pos_y <= pos_rdata;
          2'd3: begin
            pos_z      <= pos_rdata;
            read_index <= idx_reg;
          end
          default: ;
        endcase
      end
      msgs_pkg::ST_VLOAD: acc <= '0;
      msgs_pkg::ST_VCAP: begin
        pos0 <= pos_rdata;
        vel0 <= vel_rdata;
      end
      msgs_pkg::ST_NB_ACC: acc <= acc + msgs_pkg::ACC_W'(nb_term);
      msgs_pkg::ST_I1:     fh  <= nb_term;
      msgs_pkg::ST_I2:     f   <= f_new;
      msgs_pkg::ST_I4:     v1  <= v1_new;
      default: ;
    endcase
  end

  msgs_ram #(.WIDTH(msgs_pkg::DATA_W), .DEPTH(msgs_pkg::MEM_DEPTH)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  msgs_ram #(.WIDTH(msgs_pkg::DATA_W), .DEPTH(msgs_pkg::MEM_DEPTH)) u_vel_ram (
    .clk(clk), .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
    .raddr(vel_raddr), .rdata(vel_rdata)
  );

  msgs_ram #(.WIDTH(msgs_pkg::DATA_W), .DEPTH(msgs_pkg::MEM_DEPTH)) u_frc_ram (
    .clk(clk), .we(frc_we), .waddr(frc_waddr), .wdata(frc_wdata),
    .raddr(frc_raddr), .rdata(frc_rdata)
  );

  msgs_ram #(.WIDTH(msgs_pkg::DATA_W), .DEPTH(msgs_pkg::MEM_DEPTH)) u_ofrc_ram (
    .clk(clk), .we(ofrc_we), .waddr(ofrc_waddr), .wdata(ofrc_wdata),
    .raddr(ofrc_raddr), .rdata(ofrc_rdata)
  );

  // A result only ever follows the last cycle of a read.
  a_result_after_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == msgs_pkg::ST_READ &&
                           comp == msgs_pkg::AXIS_W'(msgs_pkg::NUM_AXES)))
    else $error("result strobe without a finished read");

  // The multiplier only sees old-force data fetched in the cycle before.
  a_nb_mul_order: assert property (@(posedge clk) disable iff (rst)
    state == msgs_pkg::ST_NB_MUL |-> $past(state) == msgs_pkg::ST_NB_ADDR)
    else $error("neighbour multiply without a fetch");

  // No state RAM is written while the core is idle.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == msgs_pkg::ST_IDLE |-> !(pos_we || vel_we || frc_we || ofrc_we))
    else $error("RAM write while idle");

  // A write-back of a vertex always follows its position update multiply.
  a_writeback_order: assert property (@(posedge clk) disable iff (rst)
    state == msgs_pkg::ST_I6 |-> $past(state) == msgs_pkg::ST_I5)
    else $error("vertex write-back out of order");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the mass-spring grid step core.
`default_nettype none

// The testbench drives commands and configuration writes at the falling clock edge and
// samples the core at the rising edge. Every accepted transaction is also applied to a
// behavioral copy of the cloth grid kept here. That copy holds the position, velocity and
// force of every vertex and the three gains. A read appends the vertex position it
// predicts to a queue, and each result strobe from the core is compared field by field
// against the oldest entry in that queue.
// A short table of directed commands runs first. After it come several phases of random
// commands, each phase under its own spring, damping and time step setting. A step walks
// the whole grid, so steps are kept rare.
module tb_top;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int MAX_STEPS_PER_PHASE = 6;

  typedef struct {
    logic [7:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_pos_t;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         idx;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    bit                 typed;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  logic [7:0] vertex_index = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic result_valid;
  logic [7:0] read_index;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [msgs_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mass_spring_grid_step_core dut (
    .clk, .rst, .start, .busy, .opcode, .vertex_index, .target_x, .target_y, .target_z,
    .result_valid, .read_index, .pos_x, .pos_y, .pos_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // Behavioral copy of the grid, indexed [axis][vertex].
  int grid_pos [3][msgs_pkg::NVERT];
  int grid_vel [3][msgs_pkg::NVERT];
  int grid_frc [3][msgs_pkg::NVERT];
  int prev_frc [3][msgs_pkg::NVERT];
  int k_gain, d_gain, dt_gain;

  vertex_pos_t pending_reads[$];
  int unsigned cycles = 0;
  int mismatches = 0;
  bit idle_enabled = 1'b1;

  function automatic int sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFFFFFF;
    if (v < -128'sd2147483648) return 32'h80000000;
    return int'(v[31:0]);
  endfunction

  // Floor of (p + half) / 2^sh, then saturated.
  function automatic int round_shift(logic signed [127:0] p, int sh);
    logic signed [127:0] q;
    q = p + (128'sd1 <<< (sh - 1));
    return sat32(q >>> sh);
  endfunction

  function automatic int qmul(longint a, longint b);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return round_shift(pa * pb, 16);
  endfunction

  function automatic int rest_of(int axis, int v);
    if (axis == 0) return (v % msgs_pkg::GRID_SIDE) << 16;
    if (axis == 2) return (v / msgs_pkg::GRID_SIDE) << 16;
    return 0;
  endfunction

  task automatic grid_reset();
    for (int a = 0; a < 3; a++) begin
      for (int v = 0; v < msgs_pkg::NVERT; v++) begin
        grid_pos[a][v] = rest_of(a, v);
        grid_vel[a][v] = 0;
        grid_frc[a][v] = 0;
        prev_frc[a][v] = 0;
      end
    end
    k_gain = 65536;
    d_gain = 0;
    dt_gain = 655;
  endtask

  task automatic grid_step();
    longint acc, fh, fd;
    int f, v0, v1, dx, r, c;
    logic signed [127:0] vsum;
    prev_frc = grid_frc;
    for (int a = 0; a < 3; a++) begin
      for (int v = 0; v < msgs_pkg::NVERT; v++) begin
        acc = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            r = v / msgs_pkg::GRID_SIDE + dr;
            c = v % msgs_pkg::GRID_SIDE + dc;
            if ((dr != 0 || dc != 0) && r >= 0 && c >= 0 &&
                r < msgs_pkg::GRID_SIDE && c < msgs_pkg::GRID_SIDE)
              acc += qmul(prev_frc[a][r * msgs_pkg::GRID_SIDE + c], 19661);
          end
        end
        grid_frc[a][v] = sat32(acc);
      end
    end
    for (int a = 0; a < 3; a++) begin
      for (int v = 0; v < msgs_pkg::NVERT; v++) begin
        fh = qmul(longint'(rest_of(a, v)) - longint'(grid_pos[a][v]), k_gain);
        fd = qmul(grid_vel[a][v], d_gain);
        f = sat32(longint'(grid_frc[a][v]) + fh + fd);
        v0 = grid_vel[a][v];
        v1 = sat32(longint'(v0) + qmul(f, dt_gain));
        vsum = longint'(v0) + longint'(v1);
        dx = round_shift(vsum * dt_gain, 17);
        grid_frc[a][v] = f;
        grid_vel[a][v] = v1;
        grid_pos[a][v] = sat32(longint'(grid_pos[a][v]) + longint'(dx));
      end
    end
  endtask

  // Applies one accepted command to the grid copy and queues the position a read returns.
  task automatic grid_apply(cmd_row_t row);
    vertex_pos_t rd;
    int v;
    v = row.idx;
    case (row.op)
      msgs_pkg::OP_STEP: grid_step();
      msgs_pkg::OP_PULL: begin
        grid_frc[0][v] = sat32((longint'(rest_of(0, v)) - longint'(row.tx)) * 10);
        grid_frc[1][v] = sat32((longint'(0) - longint'(row.ty)) * 10);
        grid_frc[2][v] = sat32((longint'(rest_of(2, v)) - longint'(row.tz)) * 10);
      end
      msgs_pkg::OP_READ: begin
        rd.idx = row.idx;
        if (row.typed) begin
          rd.x = row.ex;
          rd.y = row.ey;
          rd.z = row.ez;
        end else begin
          rd.x = grid_pos[0][v];
          rd.y = grid_pos[1][v];
          rd.z = grid_pos[2][v];
        end
        pending_reads = {pending_reads, rd};
      end
      default: ;
    endcase
  endtask

  // Result checker: the core cannot be stalled, so every strobe is taken at once.
  always @(posedge clk) begin
    vertex_pos_t want;
    if (!rst && result_valid) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: idx %0d pos %0d %0d %0d",
                   read_index, pos_x, pos_y, pos_z);
      end else begin
        want = pending_reads.pop_front();
        if (read_index !== want.idx || pos_x !== want.x || pos_y !== want.y ||
            pos_z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: expected idx %0d pos %0d %0d %0d, got idx %0d pos %0d %0d %0d",
                     want.idx, want.x, want.y, want.z, read_index, pos_x, pos_y, pos_z);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Two-phase register write; the register takes the value at the end of the access cycle.
  task automatic cfg_write(logic [1:0] reg_id, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = msgs_pkg::CFG_ADDR_W'({reg_id, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (reg_id)
      msgs_pkg::REG_SPRING:  k_gain = value;
      msgs_pkg::REG_DAMPING: d_gain = value;
      msgs_pkg::REG_DT:      dt_gain = {1'b0, value[30:0]};
      default: ;
    endcase
  endtask

  // Waits until all reads have returned and the core has dropped busy.
  task automatic wait_drained();
    do @(posedge clk); while (pending_reads.size() != 0 || busy);
  endtask

  // Presents one command, holds it until the core takes the transaction, and
  // may then leave start low for a short random burst.
  task automatic send_cmd(cmd_row_t row);
    @(negedge clk);
    start = 1'b1;
    opcode = row.op;
    vertex_index = row.idx;
    target_x = row.tx;
    target_y = row.ty;
    target_z = row.tz;
    do @(posedge clk); while (busy);
    grid_apply(row);
    if (idle_enabled && $urandom_range(0, 9) < 3) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  function automatic cmd_row_t mk(logic [1:0] op, logic [7:0] idx, int tx, int ty, int tz);
    cmd_row_t row;
    row.op = op;
    row.idx = idx;
    row.tx = tx;
    row.ty = ty;
    row.tz = tz;
    row.typed = 1'b0;
    row.ex = 0;
    row.ey = 0;
    row.ez = 0;
    return row;
  endfunction

  function automatic cmd_row_t mk_read(logic [7:0] idx, int ex, int ey, int ez);
    cmd_row_t row;
    row = mk(msgs_pkg::OP_READ, idx, 0, 0, 0);
    row.typed = 1'b1;
    row.ex = ex;
    row.ey = ey;
    row.ez = ez;
    return row;
  endfunction

  function automatic int rand_target();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : 32'h80000000;
      default: return int'($urandom_range(0, 20 << 16)) - (2 << 16);
    endcase
  endfunction

  function automatic logic [7:0] rand_index();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1: return 8'(msgs_pkg::GRID_SIDE * $urandom_range(0, msgs_pkg::GRID_SIDE - 1));
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    cmd_row_t directed[$];
    cmd_row_t row;
    int steps;
    logic [31:0] k_set [4];
    logic [31:0] d_set [4];
    logic [31:0] dt_set [4];

    grid_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Rest positions are visible right after reset, before any step.
    directed = {directed, mk_read(8'd0, 0, 0, 0)};
    directed = {directed, mk_read(8'd255, 15 << 16, 0, 15 << 16)};
    directed = {directed, mk_read(8'd17, 1 << 16, 0, 1 << 16)};
    directed = {directed, mk_read(8'd15, 15 << 16, 0, 0)};
    // The unused opcode does nothing and returns nothing.
    directed = {directed, mk(OP_NONE, 8'd3, 32'h7FFFFFFF, 0, 32'h80000000)};
    directed = {directed, mk_read(8'd3, 3 << 16, 0, 0)};
    // Pulls at the corners with extreme targets, which saturate, then at the middle and an edge.
    directed = {directed, mk(msgs_pkg::OP_PULL, 8'd0, 32'h7FFFFFFF, 32'h80000000,
                             32'h7FFFFFFF)};
    directed = {directed, mk(msgs_pkg::OP_PULL, 8'd255, 32'h80000000, 32'h7FFFFFFF,
                             32'h80000000)};
    directed = {directed, mk(msgs_pkg::OP_PULL, 8'd136, 9 << 16, 1 << 16, 7 << 16)};
    directed = {directed, mk(msgs_pkg::OP_PULL, 8'd7, 32'hFFFFFFFF, 0, 1)};
    // A pull alone moves nothing until a step runs.
    directed = {directed, mk_read(8'd136, 8 << 16, 0, 8 << 16)};
    directed = {directed, mk(msgs_pkg::OP_STEP, 8'd0, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd0, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd1, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd136, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd137, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd254, 0, 0, 0)};
    // A second step carries the spread forces one ring further out.
    directed = {directed, mk(msgs_pkg::OP_STEP, 8'd99, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd255, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd119, 0, 0, 0)};
    directed = {directed, mk(msgs_pkg::OP_READ, 8'd2, 0, 0, 0)};

    foreach (directed[i]) send_cmd(directed[i]);

    // Settings per random phase, with the extremes of every register among them.
    k_set  = '{32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    d_set  = '{32'hFFFF_C000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    dt_set = '{32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_028F};

    for (int phase = 0; phase < 4; phase++) begin
      // Pause the command side until the grid has fully settled, then reconfigure.
      @(negedge clk);
      start = 1'b0;
      wait_drained();
      cfg_write(msgs_pkg::REG_SPRING, k_set[phase]);
      cfg_write(msgs_pkg::REG_DAMPING, d_set[phase]);
      cfg_write(msgs_pkg::REG_DT, dt_set[phase]);
      idle_enabled = (phase != 3);
      steps = 0;
      for (int n = 0; n < 30; n++) begin
        row = mk(msgs_pkg::OP_READ, rand_index(), rand_target(), rand_target(),
                 rand_target());
        case ($urandom_range(0, 19))
          0, 1: begin
            if (steps < MAX_STEPS_PER_PHASE) begin
              row.op = msgs_pkg::OP_STEP;
              steps++;
            end
          end
          2: row.op = OP_NONE;
          3, 4, 5, 6, 7, 8, 9: row.op = msgs_pkg::OP_PULL;
          default: ;
        endcase
        send_cmd(row);
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
